// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker of the hyperbola plotter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is high.
`define HPP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define HPP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/hpp_pkg.sv =====
// Shared constants, types and the cosh/sinh table of the hyperbola plotter.
`default_nettype none

package hpp_pkg;

   localparam int NUM_STEPS       = 71;
   localparam int TABLE_DEPTH     = (NUM_STEPS < 128) ? NUM_STEPS : 128;
   localparam int TIDX_W          = $clog2(TABLE_DEPTH);
   localparam int SERIES_TERMS    = 64;

   localparam int STEP_W          = 7;
   localparam int CX_W            = 12;
   localparam int AX_W            = 11;
   localparam int Q_W             = 21;
   localparam int FRAC_W          = 16;
   localparam int PIX_W           = 16;
   localparam int OFF_W           = AX_W - 1 + Q_W;
   localparam int SUM_W           = OFF_W + 2;

   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 12;

   localparam int PIXELS_PER_STEP = 4;
   localparam int SLOT_W          = 2;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PIXELS_PER_STEP - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEMI_AXIS_A   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEMI_AXIS_B   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTICAL_MODE = 3'd4;

   localparam logic [Q_W-1:0] TABLE_MAX = 21'h1FFFFF;

   typedef logic [Q_W-1:0] q16_type;

   typedef struct packed {
      logic [CX_W-1:0] center_x;
      logic [CX_W-1:0] center_y;
      logic [AX_W-1:0] semi_axis_a;
      logic [AX_W-1:0] semi_axis_b;
      logic            vertical_mode;
   } cfg_type;

   typedef struct packed {
      q16_type ch;
      q16_type sh;
   } hyp_entry_type;

   typedef hyp_entry_type [TABLE_DEPTH-1:0] hyp_table_type;

   typedef struct packed {
      logic [PIX_W-1:0] x_plus;
      logic [PIX_W-1:0] x_minus;
      logic [PIX_W-1:0] y_plus;
      logic [PIX_W-1:0] y_minus;
   } coord_type;

   // Rounds a Q48 sum to Q16 and clamps it to the Q5.16 range.
   function automatic q16_type to_q16(input logic [63:0] q48);
      logic [63:0] r;
      r = (q48 + (64'd1 << 31)) >> 32;
      return (r > 64'(TABLE_MAX)) ? TABLE_MAX : r[Q_W-1:0];
   endfunction

   // Even and odd parts of the power series of e^(k/20), evaluated at elaboration.
   function automatic hyp_table_type hyp_build();
      hyp_table_type tbl;
      logic [63:0]   term;
      logic [63:0]   even;
      logic [63:0]   odd;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         term = 64'd1 << 48;
         even = term;
         odd  = '0;
         for (int n = 1; n < SERIES_TERMS; n++) begin
            term = (term * 64'(k)) / 64'(20 * n);
            if ((n & 1) != 0) begin
               odd = odd + term;
            end else begin
               even = even + term;
            end
         end
         tbl[k].ch = to_q16(even);
         tbl[k].sh = to_q16(odd);
      end
      return tbl;
   endfunction

   localparam hyp_table_type HYP_TABLE = hyp_build();

endpackage

`default_nettype wire

// ===== rtl/hpp_lookup.sv =====
// Input register and cosh/sinh table lookup stages.
`default_nettype none

module hpp_lookup import hpp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire logic [STEP_W-1:0] in_step,
   output      logic              out_valid,
   input  wire logic              out_ready,
   output      hyp_entry_type     out_entry
);

   logic              v1_ff, v1_in;
   logic              v2_ff, v2_in;
   logic [TIDX_W-1:0] idx_ff, idx_in;
   hyp_entry_type     entry_ff, entry_in;
   logic              ld1, ld2;
   logic              a_pos, b_pos, step_ok;

   assign ld2      = !v2_ff || out_ready;
   assign ld1      = !v1_ff || ld2;
   assign in_ready = ld1;

   assign a_pos   = !cfg.semi_axis_a[AX_W-1] && (cfg.semi_axis_a != '0);
   assign b_pos   = !cfg.semi_axis_b[AX_W-1] && (cfg.semi_axis_b != '0);
   assign step_ok = 32'(in_step) < NUM_STEPS;

   // Items that produce no pixels are accepted but never enter the pipeline.
   always_comb begin
      v1_in    = v1_ff;
      idx_in   = idx_ff;
      v2_in    = v2_ff;
      entry_in = entry_ff;
      if (ld1) begin
         v1_in  = in_valid && a_pos && b_pos && step_ok;
         idx_in = in_step[TIDX_W-1:0];
      end
      if (ld2) begin
         v2_in    = v1_ff;
         entry_in = HYP_TABLE[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      idx_ff   <= idx_in;
      entry_ff <= entry_in;
   end

   assign out_valid = v2_ff;
   assign out_entry = entry_ff;

endmodule

`default_nettype wire

// ===== rtl/hpp_arith.sv =====
// Scaling, center offset and rounding stages.
`default_nettype none

module hpp_arith import hpp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire logic          in_valid,
   output      logic          in_ready,
   input  wire hyp_entry_type in_entry,
   output      logic          out_valid,
   input  wire logic          out_ready,
   output      coord_type     out_coord
);

   logic                    v3_ff, v3_in;
   logic                    v4_ff, v4_in;
   logic                    v5_ff, v5_in;
   logic [OFF_W-1:0]        xoff_ff, xoff_in;
   logic [OFF_W-1:0]        yoff_ff, yoff_in;
   logic signed [SUM_W-1:0] xp_ff, xp_in, xm_ff, xm_in;
   logic signed [SUM_W-1:0] yp_ff, yp_in, ym_ff, ym_in;
   coord_type               coord_ff, coord_in;
   logic                    ld3, ld4, ld5;
   logic [OFF_W-1:0]        ea, eb;
   logic signed [SUM_W-1:0] base_x, base_y, off_x, off_y;

   // Round half away from zero, then clamp to the pixel range.
   function automatic logic [PIX_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0]        t;
      logic signed [SUM_W-FRAC_W-1:0] r;
      t = v + (v[SUM_W-1] ? SUM_W'(32767) : SUM_W'(32768));
      r = t[SUM_W-1:FRAC_W];
      if (r[PIX_W] != r[PIX_W-1]) begin
         return r[PIX_W] ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
      end
      return r[PIX_W-1:0];
   endfunction

   assign ld5      = !v5_ff || out_ready;
   assign ld4      = !v4_ff || ld5;
   assign ld3      = !v3_ff || ld4;
   assign in_ready = ld3;

   // The axes are known positive here, so their sign bit is dropped.
   assign ea = OFF_W'(cfg.semi_axis_a[AX_W-2:0]) * OFF_W'(in_entry.ch);
   assign eb = OFF_W'(cfg.semi_axis_b[AX_W-2:0]) * OFF_W'(in_entry.sh);

   assign base_x = {{(SUM_W-CX_W-FRAC_W){cfg.center_x[CX_W-1]}}, cfg.center_x, {FRAC_W{1'b0}}};
   assign base_y = {{(SUM_W-CX_W-FRAC_W){cfg.center_y[CX_W-1]}}, cfg.center_y, {FRAC_W{1'b0}}};
   assign off_x  = {2'b00, xoff_ff};
   assign off_y  = {2'b00, yoff_ff};

   always_comb begin
      v3_in    = v3_ff;
      xoff_in  = xoff_ff;
      yoff_in  = yoff_ff;
      v4_in    = v4_ff;
      xp_in    = xp_ff;
      xm_in    = xm_ff;
      yp_in    = yp_ff;
      ym_in    = ym_ff;
      v5_in    = v5_ff;
      coord_in = coord_ff;
      if (ld3) begin
         v3_in   = in_valid;
         xoff_in = cfg.vertical_mode ? eb : ea;
         yoff_in = cfg.vertical_mode ? ea : eb;
      end
      if (ld4) begin
         v4_in = v3_ff;
         xp_in = base_x + off_x;
         xm_in = base_x - off_x;
         yp_in = base_y + off_y;
         ym_in = base_y - off_y;
      end
      if (ld5) begin
         v5_in            = v4_ff;
         coord_in.x_plus  = round_sat(xp_ff);
         coord_in.x_minus = round_sat(xm_ff);
         coord_in.y_plus  = round_sat(yp_ff);
         coord_in.y_minus = round_sat(ym_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
      xoff_ff  <= xoff_in;
      yoff_ff  <= yoff_in;
      xp_ff    <= xp_in;
      xm_ff    <= xm_in;
      yp_ff    <= yp_in;
      ym_ff    <= ym_in;
      coord_ff <= coord_in;
   end

   assign out_valid = v5_ff;
   assign out_coord = coord_ff;

endmodule

`default_nettype wire

// ===== rtl/hpp_serial.sv =====
// Output register that hands out the four mirror pixels of one step.
`default_nettype none

module hpp_serial import hpp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              vertical_mode,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire coord_type         in_coord,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [PIX_W-1:0]  rsp_pixel_x,
   output      logic [PIX_W-1:0]  rsp_pixel_y,
   output      logic              rsp_last_pixel
);

   logic              v_ff, v_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   coord_type         coord_ff, coord_in;
   logic              last, ld, x_neg, y_neg;

   assign last     = slot_ff == LAST_SLOT;
   assign ld       = !v_ff || (rsp_ready && last);
   assign in_ready = ld;

   always_comb begin
      v_in     = v_ff;
      slot_in  = slot_ff;
      coord_in = coord_ff;
      if (ld) begin
         v_in     = in_valid;
         slot_in  = '0;
         coord_in = in_coord;
      end else if (rsp_ready) begin
         slot_in = slot_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= 1'b0;
         slot_ff <= '0;
      end else begin
         v_ff    <= v_in;
         slot_ff <= slot_in;
      end
      coord_ff <= coord_in;
   end

   // Horizontal mode walks y fastest, vertical mode walks x fastest.
   assign x_neg = vertical_mode ? slot_ff[0] : slot_ff[1];
   assign y_neg = vertical_mode ? slot_ff[1] : slot_ff[0];

   assign rsp_valid      = v_ff;
   assign rsp_pixel_x    = x_neg ? coord_ff.x_minus : coord_ff.x_plus;
   assign rsp_pixel_y    = y_neg ? coord_ff.y_minus : coord_ff.y_plus;
   assign rsp_last_pixel = last;

endmodule

`default_nettype wire

// ===== rtl/parametric_hyperbola_plotter_top.sv =====
// Top level of the parametric hyperbola plotter: registers and pipeline wiring.
// Each accepted item names a step k (t = k/20); the block looks up cosh(t) and sinh(t),
// scales them by the semi-axes, offsets them from the center and rounds half away from
// zero, then returns the four mirror pixels of both branches, one per cycle while
// rsp_ready is high, with rsp_last_pixel set on the fourth. The item passes the input,
// lookup, scaling, offset, rounding and output registers before its first pixel. The
// output stage, at four pixels per item, sets the throughput; the pipeline ahead holds
// five more items. Items with a step of NUM_STEPS or more, or taken while either
// semi-axis is not positive, are accepted and produce no pixels. Registers are written
// through the csr port while the block is idle; the user ensures this, not the block.
`default_nettype none

module parametric_hyperbola_plotter_top import hpp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [STEP_W-1:0]     req_step_index,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [PIX_W-1:0]      rsp_pixel_x,
   output      logic [PIX_W-1:0]      rsp_pixel_y,
   output      logic                  rsp_last_pixel
);

   cfg_type       cfg_ff, cfg_in;
   logic          lk_valid, lk_ready;
   hyp_entry_type lk_entry;
   logic          ar_valid, ar_ready;
   coord_type     ar_coord;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_CENTER_X:      cfg_in.center_x      = csr_wdata[CX_W-1:0];
            CSR_CENTER_Y:      cfg_in.center_y      = csr_wdata[CX_W-1:0];
            CSR_SEMI_AXIS_A:   cfg_in.semi_axis_a   = csr_wdata[AX_W-1:0];
            CSR_SEMI_AXIS_B:   cfg_in.semi_axis_b   = csr_wdata[AX_W-1:0];
            CSR_VERTICAL_MODE: cfg_in.vertical_mode = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x      <= '0;
         cfg_ff.center_y      <= '0;
         cfg_ff.semi_axis_a   <= AX_W'(1);
         cfg_ff.semi_axis_b   <= AX_W'(1);
         cfg_ff.vertical_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hpp_lookup u_lookup (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_step   (req_step_index),
      .out_valid (lk_valid),
      .out_ready (lk_ready),
      .out_entry (lk_entry)
   );

   hpp_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (lk_valid),
      .in_ready  (lk_ready),
      .in_entry  (lk_entry),
      .out_valid (ar_valid),
      .out_ready (ar_ready),
      .out_coord (ar_coord)
   );

   hpp_serial u_serial (
      .clock          (clock),
      .reset          (reset),
      .vertical_mode  (cfg_ff.vertical_mode),
      .in_valid       (ar_valid),
      .in_ready       (ar_ready),
      .in_coord       (ar_coord),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

`default_nettype wire

// ===== rtl/hpp_checker.sv =====
// Port-level checker for the hyperbola plotter, bound to its top level.
`default_nettype none

`include "assert_macros.svh"

module hpp_checker import hpp_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [PIX_W-1:0]      rsp_pixel_x,
   input wire logic [PIX_W-1:0]      rsp_pixel_y,
   input wire logic                  rsp_last_pixel
);

   // Nothing is pending right after reset.
   `HPP_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // The input only stalls when the output holds a waiting item.
   `HPP_ASSERT(a_stall_cause, !req_ready |-> rsp_valid, "input stalled with no result pending")

   // The four pixels of a step come out without a gap.
   `HPP_ASSERT(a_no_gap, (rsp_valid && rsp_ready && !rsp_last_pixel) |=> rsp_valid,
      "gap inside the pixels of one step")

   // A waiting result holds its payload.
   `HPP_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_last_pixel)),
      "stalled result changed")

endmodule

bind parametric_hyperbola_plotter_top hpp_checker u_hpp_checker (.*);

`default_nettype wire

// ===== tb/hyperbola_pixel_checker.sv =====
// Predicts and checks the four mirror pixels of each accepted step that makes pixels.
module hyperbola_pixel_checker import hpp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [STEP_W-1:0]     req_step_index,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [PIX_W-1:0]      rsp_pixel_x,
   input  logic [PIX_W-1:0]      rsp_pixel_y,
   input  logic                  rsp_last_pixel,
   output int                    pending,
   output int                    failures
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
      logic             last_pixel;
   } pixel_type;

   pixel_type expected_pixels[$];

   logic signed [CX_W-1:0] center_x;
   logic signed [CX_W-1:0] center_y;
   logic signed [AX_W-1:0] axis_a;
   logic signed [AX_W-1:0] axis_b;
   logic                   vertical;
   int                     error_total = 0;

   // One curve table entry: even and odd halves of the series of e^(k/20), summed in Q48.
   function automatic void hyp_series(input int unsigned k, output logic [Q_W-1:0] ch,
                                      output logic [Q_W-1:0] sh);
      longint unsigned term;
      longint unsigned even_sum;
      longint unsigned odd_sum;
      longint unsigned rounded;
      term     = 64'd1 << 48;
      even_sum = term;
      odd_sum  = 64'd0;
      for (int n = 1; n < SERIES_TERMS; n++) begin
         term = (term * 64'(k)) / 64'(20 * n);
         if (n % 2 == 1) begin
            odd_sum += term;
         end else begin
            even_sum += term;
         end
      end
      rounded = (even_sum + (64'd1 << 31)) >> 32;
      ch = (rounded > 64'(TABLE_MAX)) ? TABLE_MAX : rounded[Q_W-1:0];
      rounded = (odd_sum + (64'd1 << 31)) >> 32;
      sh = (rounded > 64'(TABLE_MAX)) ? TABLE_MAX : rounded[Q_W-1:0];
   endfunction

   function automatic logic [PIX_W-1:0] round_to_pixel(input longint v);
      longint r;
      if (v >= 0) begin
         r = (v + 32768) / 65536;
      end else begin
         r = -((-v + 32768) / 65536);
      end
      if (r > 32767) begin
         r = 32767;
      end
      if (r < -32768) begin
         r = -32768;
      end
      return r[PIX_W-1:0];
   endfunction

   function automatic pixel_type make_pixel(input logic [PIX_W-1:0] x,
                                            input logic [PIX_W-1:0] y, input logic last);
      pixel_type p;
      p.x          = x;
      p.y          = y;
      p.last_pixel = last;
      return p;
   endfunction

   function automatic void predict_step(input logic [STEP_W-1:0] k);
      logic [Q_W-1:0]   ch;
      logic [Q_W-1:0]   sh;
      longint           ea;
      longint           eb;
      longint           cx_q;
      longint           cy_q;
      logic [PIX_W-1:0] p_plus;
      logic [PIX_W-1:0] p_minus;
      logic [PIX_W-1:0] q_plus;
      logic [PIX_W-1:0] q_minus;
      if (axis_a <= 0 || axis_b <= 0 || int'(k) >= NUM_STEPS) begin
         return;
      end
      hyp_series(int'(k), ch, sh);
      ea   = longint'(axis_a) * longint'(ch);
      eb   = longint'(axis_b) * longint'(sh);
      cx_q = longint'(center_x) * 65536;
      cy_q = longint'(center_y) * 65536;
      if (!vertical) begin
         p_plus  = round_to_pixel(cx_q + ea);
         p_minus = round_to_pixel(cx_q - ea);
         q_plus  = round_to_pixel(cy_q + eb);
         q_minus = round_to_pixel(cy_q - eb);
         expected_pixels.push_back(make_pixel(p_plus, q_plus, 1'b0));
         expected_pixels.push_back(make_pixel(p_plus, q_minus, 1'b0));
         expected_pixels.push_back(make_pixel(p_minus, q_plus, 1'b0));
         expected_pixels.push_back(make_pixel(p_minus, q_minus, 1'b1));
      end else begin
         p_plus  = round_to_pixel(cx_q + eb);
         p_minus = round_to_pixel(cx_q - eb);
         q_plus  = round_to_pixel(cy_q + ea);
         q_minus = round_to_pixel(cy_q - ea);
         expected_pixels.push_back(make_pixel(p_plus, q_plus, 1'b0));
         expected_pixels.push_back(make_pixel(p_minus, q_plus, 1'b0));
         expected_pixels.push_back(make_pixel(p_plus, q_minus, 1'b0));
         expected_pixels.push_back(make_pixel(p_minus, q_minus, 1'b1));
      end
   endfunction

   always @(posedge clock) begin : monitor
      pixel_type want;
      if (reset) begin
         center_x = '0;
         center_y = '0;
         axis_a   = AX_W'(1);
         axis_b   = AX_W'(1);
         vertical = 1'b0;
         expected_pixels.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_CENTER_X:      center_x = csr_wdata[CX_W-1:0];
               CSR_CENTER_Y:      center_y = csr_wdata[CX_W-1:0];
               CSR_SEMI_AXIS_A:   axis_a   = csr_wdata[AX_W-1:0];
               CSR_SEMI_AXIS_B:   axis_b   = csr_wdata[AX_W-1:0];
               CSR_VERTICAL_MODE: vertical = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel with no item outstanding: x %0d y %0d last %0d",
                      $signed(rsp_pixel_x), $signed(rsp_pixel_y), rsp_last_pixel);
               error_total++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_x !== want.x) begin
                  $error("pixel_x expected %0d actual %0d", $signed(want.x),
                         $signed(rsp_pixel_x));
                  error_total++;
               end
               if (rsp_pixel_y !== want.y) begin
                  $error("pixel_y expected %0d actual %0d", $signed(want.y),
                         $signed(rsp_pixel_y));
                  error_total++;
               end
               if (rsp_last_pixel !== want.last_pixel) begin
                  $error("last_pixel expected %0d actual %0d", want.last_pixel,
                         rsp_last_pixel);
                  error_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_step(req_step_index);
         end
      end
      pending  <= expected_pixels.size();
      failures <= error_total;
   end

endmodule

// ===== tb/parametric_hyperbola_plotter_top_test.sv =====
// Top of the hyperbola plotter test: clock, reset, stimulus and the final verdict.
module parametric_hyperbola_plotter_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import hpp_pkg::*;

   localparam int RANDOM_ITEMS = 480;
   localparam int IDLE_CYCLES  = 40;
   localparam int CYCLE_LIMIT  = 500000;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 3'd5;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [STEP_W-1:0]     req_step_index = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_x;
   logic [PIX_W-1:0]      rsp_pixel_y;
   logic                  rsp_last_pixel;
   int                    pending;
   int                    failures;
   int                    cycle_count    = 0;
   bit                    sender_no_idle = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   parametric_hyperbola_plotter_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_step_index (req_step_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel)
   );

   hyperbola_pixel_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_step_index (req_step_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel),
      .pending        (pending),
      .failures       (failures)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 20);
   endfunction

   // Uniform over the range, with the two ends picked more often.
   function automatic int pick_value(input int lo, input int hi);
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) begin
         return lo;
      end else if (r == 1) begin
         return hi;
      end
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   task automatic send_step(input logic [STEP_W-1:0] k);
      int gap;
      gap = sender_no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_step_index <= k;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drops req_valid, lets every expected pixel arrive, then idles before returning.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= d;
      @(posedge clock);
   endtask

   // Writes all registers plus one write to an unused index, which must be ignored.
   task automatic program_config(input int cx, input int cy, input int a, input int b,
                                 input bit vm);
      csr_write(CSR_CENTER_X, CSR_DATA_W'(cx));
      csr_write(CSR_CENTER_Y, CSR_DATA_W'(cy));
      csr_write(CSR_SEMI_AXIS_A, {1'($urandom_range(0, 1)), AX_W'(a)});
      csr_write(CSR_SEMI_AXIS_B, {1'($urandom_range(0, 1)), AX_W'(b)});
      csr_write(CSR_VERTICAL_MODE, {11'($urandom_range(0, 2047)), vm});
      csr_write(CSR_FIRST_UNUSED + CSR_IDX_W'($urandom_range(0, 2)),
                CSR_DATA_W'($urandom_range(0, 4095)));
      csr_write_en <= 1'b0;
   endtask

   initial begin : receiver
      int run;
      int stall;
      forever begin
         run = $urandom_range(1, 30);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      int counted;
      int phase_len;
      int cx;
      int cy;
      int a;
      int b;
      bit vm;
      bit disabled;
      logic [STEP_W-1:0] k;
      counted = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings, first and last step, and steps past the end of the curve.
      send_step(7'd0);
      send_step(7'd70);
      send_step(7'd71);
      send_step(7'd127);
      send_step(7'd35);
      wait_idle();

      // Largest axes with the center at a corner in both modes, then the opposite corner with b = 1.
      program_config(2047, -2048, 1023, 1023, 1'b0);
      send_step(7'd0);
      send_step(7'd70);
      send_step(7'd1);
      wait_idle();
      program_config(2047, -2048, 1023, 1023, 1'b1);
      send_step(7'd70);
      send_step(7'd0);
      wait_idle();
      program_config(-2048, 2047, 1023, 1, 1'b1);
      send_step(7'd70);
      send_step(7'd69);
      wait_idle();

      // A semi-axis that is zero or negative disables all pixels.
      program_config(100, -100, 0, 5, 1'b0);
      send_step(7'd10);
      wait_idle();
      program_config(100, -100, -1024, 5, 1'b0);
      send_step(7'd5);
      wait_idle();
      program_config(-5, 5, 5, -1, 1'b1);
      send_step(7'd5);
      wait_idle();
      program_config(-5, 5, 5, 0, 1'b0);
      send_step(7'd5);
      wait_idle();

      while (counted < RANDOM_ITEMS) begin
         disabled = ($urandom_range(0, 7) == 0);
         cx = pick_value(-2048, 2047);
         cy = pick_value(-2048, 2047);
         a  = pick_value(1, 1023);
         b  = pick_value(1, 1023);
         if (disabled) begin
            if ($urandom_range(0, 1) == 0) begin
               a = pick_value(-1024, 0);
            end else begin
               b = pick_value(-1024, 0);
            end
         end
         vm             = 1'($urandom_range(0, 1));
         sender_no_idle = ($urandom_range(0, 3) == 0);
         program_config(cx, cy, a, b, vm);
         phase_len = disabled ? $urandom_range(4, 10) : $urandom_range(20, 60);
         repeat (phase_len) begin
            if ($urandom_range(0, 9) == 0) begin
               k = STEP_W'($urandom_range(NUM_STEPS, 127));
            end else begin
               k = STEP_W'($urandom_range(0, NUM_STEPS - 1));
            end
            send_step(k);
            counted++;
         end
         wait_idle();
      end

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== parametric_hyperbola_plotter_top.f =====
+incdir+rtl
rtl/hpp_pkg.sv
rtl/hpp_lookup.sv
rtl/hpp_arith.sv
rtl/hpp_serial.sv
rtl/parametric_hyperbola_plotter_top.sv
rtl/hpp_checker.sv
tb/hyperbola_pixel_checker.sv
tb/parametric_hyperbola_plotter_top_test.sv
